// ----- src/hrhp_pkg.sv -----
// Package: shared types and constants of the HTTP request header parser.
package hrhp_pkg;

  localparam int unsigned VerdictW = 2;

  typedef enum logic [1:0] {
    VERDICT_GET  = 2'd0,
    VERDICT_POST = 2'd1,
    VERDICT_BAD  = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        keep_alive;
    logic [15:0] url_offset;
    logic [15:0] url_length;
    logic [15:0] version_offset;
    logic [15:0] version_length;
    logic [31:0] content_length;
    logic [15:0] body_offset;
  } result_t;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChPlus  = 8'h2b;

  // Lowercase a character.
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSp) || (c == ChTab);
  endfunction

  function automatic logic [7:0] get_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h47;
      3'd1:    r = 8'h45;
      3'd2:    r = 8'h54;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] post_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h50;
      3'd1:    r = 8'h4f;
      3'd2:    r = 8'h53;
      3'd3:    r = 8'h54;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "connection", lowercase.
  function automatic logic [7:0] conn_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0:    r = "c";
      4'd1:    r = "o";
      4'd2:    r = "n";
      4'd3:    r = "n";
      4'd4:    r = "e";
      4'd5:    r = "c";
      4'd6:    r = "t";
      4'd7:    r = "i";
      4'd8:    r = "o";
      4'd9:    r = "n";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "content-length", lowercase.
  function automatic logic [7:0] clen_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0:    r = "c";
      4'd1:    r = "o";
      4'd2:    r = "n";
      4'd3:    r = "t";
      4'd4:    r = "e";
      4'd5:    r = "n";
      4'd6:    r = "t";
      4'd7:    r = "-";
      4'd8:    r = "l";
      4'd9:    r = "e";
      4'd10:   r = "n";
      4'd11:   r = "g";
      4'd12:   r = "t";
      4'd13:   r = "h";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] close_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = "c";
      3'd1:    r = "l";
      3'd2:    r = "o";
      3'd3:    r = "s";
      3'd4:    r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- src/hrhp_if.sv -----
// Interfaces: input byte channel and result channel.
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface hrhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic        keep_alive;
  logic [15:0] url_offset;
  logic [15:0] url_length;
  logic [15:0] version_offset;
  logic [15:0] version_length;
  logic [31:0] content_length;
  logic [15:0] body_offset;
  modport source (output valid, output verdict, output keep_alive, output url_offset,
                  output url_length, output version_offset, output version_length,
                  output content_length, output body_offset, input ready);
  modport sink (input valid, input verdict, input keep_alive, input url_offset,
                input url_length, input version_offset, input version_length,
                input content_length, input body_offset, output ready);
endinterface

// ----- src/hrhp_out_skid.sv -----
// Two-entry output buffer for result items.
module hrhp_out_skid (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  hrhp_pkg::result_t     data_i,
  output logic                  space_o,
  hrhp_out_if.source            out_o
);
  import hrhp_pkg::*;

  result_t   main_q, skid_q;
  logic      main_vld_q, skid_vld_q;
  logic      pop;

  assign pop     = out_o.valid && out_o.ready;
  assign space_o = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (pop || !main_vld_q) begin
        // advance the skid entry, else take the new item
        if (skid_vld_q) begin
          main_vld_q <= 1'b1;
          skid_vld_q <= push_i;
        end else begin
          main_vld_q <= push_i;
        end
      end else if (push_i) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !main_vld_q) begin
      if (skid_vld_q) begin
        main_q <= skid_q;
        if (push_i) skid_q <= data_i;
      end else if (push_i) begin
        main_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign out_o.valid          = main_vld_q;
  assign out_o.verdict        = main_q.verdict;
  assign out_o.keep_alive     = main_q.keep_alive;
  assign out_o.url_offset     = main_q.url_offset;
  assign out_o.url_length     = main_q.url_length;
  assign out_o.version_offset = main_q.version_offset;
  assign out_o.version_length = main_q.version_length;
  assign out_o.content_length = main_q.content_length;
  assign out_o.body_offset    = main_q.body_offset;

endmodule

// ----- src/http_request_header_parser.sv -----
// Top level: HTTP/1.1 request header parser, one byte per transfer.
//
//  channel  | dir | payload                                   | transfer
//  in_i     | in  | in_byte                                   | valid & ready
//  out_o    | out | verdict, keep_alive, offsets, lengths ... | valid & ready
//
// One byte per clock while the output buffer has space: each accepted byte updates the
// parse registers, and its verdict enters a two-entry output buffer in the same cycle.
// Reset puts the parser at the start of a request line with empty buffer.
// in_i.ready drops only while the output buffer is full; an output stall
// therefore holds the input after at most two pending verdicts.
module http_request_header_parser #(
  parameter int unsigned POS_BITS = 16,
  parameter int unsigned LEN_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrhp_in_if.sink    in_i,
  hrhp_out_if.source out_o
);
  import hrhp_pkg::*;

  localparam logic [1:0] PhLine = 2'd0;
  localparam logic [1:0] PhHdr  = 2'd1;
  localparam logic [1:0] PhBody = 2'd2;
  localparam logic [1:0] KOther = 2'd0;
  localparam logic [1:0] KGet   = 2'd1;
  localparam logic [1:0] KPost  = 2'd2;
  localparam logic [POS_BITS-1:0] PosMax = '1;
  localparam logic [LEN_BITS-1:0] LenMax = '1;
  localparam logic [LEN_BITS-1:0] LenDiv = LenMax / 10;
  localparam logic [LEN_BITS-1:0] LenRem = LenMax % 10;

  typedef struct packed {
    logic [1:0]          phase;
    logic                cr;
    logic [POS_BITS-1:0] pos;
    logic [2:0]          rl_step;
    logic [1:0]          kind;
    logic [2:0]          mcnt;
    logic [POS_BITS-1:0] url_start;
    logic [POS_BITS-1:0] url_size;
    logic [POS_BITS-1:0] ver_start;
    logic [POS_BITS-1:0] ver_size;
    logic [2:0]          h_step;
    logic [3:0]          name_idx;
    logic [1:0]          flags;
    logic [2:0]          val_idx;
    logic                close_m;
    logic [LEN_BITS-1:0] accum;
    logic [LEN_BITS-1:0] length;
    logic                keep;
    logic [LEN_BITS-1:0] remain;
    logic [POS_BITS-1:0] body_start;
    logic                empty;
  } st_t;

  localparam st_t StRst = '{flags: 2'b11, close_m: 1'b1, keep: 1'b1, empty: 1'b1,
                            default: '0};

  st_t s_q, s_d;
  logic       take, space, emit;
  logic [1:0] verd;
  result_t    res;
  logic [7:0] c;

  assign c     = in_i.in_byte;
  assign in_i.ready = space;
  assign take  = in_i.valid && space;

  // Digit add with saturation at the accumulator limit.
  function automatic logic [LEN_BITS-1:0] add_dig(input logic [LEN_BITS-1:0] a,
                                                  input logic [3:0] d);
    logic over;
    over = (a > LenDiv) || ((a == LenDiv) && (LEN_BITS'(d) > LenRem));
    return over ? LenMax : (a * LEN_BITS'(10)) + LEN_BITS'(d);
  endfunction

  always_comb begin
    logic       isdig, hit, endln, eline;
    logic [1:0] f;
    st_t        n;
    n     = s_q;
    emit  = 1'b0;
    verd  = VERDICT_BAD;
    isdig = (c >= "0") && (c <= "9");
    hit   = 1'b0;
    endln = 1'b0;
    eline = 1'b0;
    f     = 2'b00;
    n.pos = s_q.pos + 1'b1;
    if (s_q.pos == PosMax) begin
      emit = 1'b1;
    end else if (s_q.phase == PhBody) begin
      if (s_q.remain <= LEN_BITS'(1)) begin
        emit = 1'b1;
        verd = VERDICT_POST;
      end
      n.remain = (s_q.remain != '0) ? s_q.remain - 1'b1 : s_q.remain;
    end else if (s_q.cr) begin
      n.cr = 1'b0;
      if (c != ChLf) emit = 1'b1;
      else endln = 1'b1;
    end else if (c == ChCr) begin
      n.cr = 1'b1;
      if (s_q.phase == PhLine && s_q.rl_step == 3'd4) n.ver_start = s_q.pos;
    end else if (s_q.phase == PhHdr) begin
      // header line byte
      hit = 1'b0;
      if (s_q.h_step == 3'd0 && !is_blank(c)) begin
        n.empty = 1'b0;
        hit = 1'b1;
      end
      if (s_q.h_step == 3'd1 || hit) begin
        n.h_step = 3'd1;
        if (c == ChColon) begin
          f[0] = s_q.flags[0] && (s_q.name_idx == 4'd10);
          f[1] = s_q.flags[1] && (s_q.name_idx == 4'd14);
          n.flags  = f;
          n.h_step = 3'd2;
        end else begin
          if (s_q.name_idx >= 4'd10 || to_lower(c) != conn_char(s_q.name_idx))
            n.flags[0] = 1'b0;
          if (s_q.name_idx >= 4'd14 || to_lower(c) != clen_char(s_q.name_idx))
            n.flags[1] = 1'b0;
          if (s_q.name_idx < 4'd15) n.name_idx = s_q.name_idx + 1'b1;
        end
      end else if (s_q.h_step >= 3'd2) begin
        hit = 1'b1;
        if (s_q.h_step == 3'd2) begin
          if (is_blank(c)) hit = 1'b0;
          else if (s_q.flags[1] && (c == ChLf || c == ChVt || c == ChFf)) hit = 1'b0;
        end
        if (hit) begin
          if (s_q.val_idx >= 3'd5 || to_lower(c) != close_char(s_q.val_idx))
            n.close_m = 1'b0;
          if (s_q.val_idx < 3'd7) n.val_idx = s_q.val_idx + 1'b1;
          if (s_q.h_step == 3'd2) begin
            if (c == ChPlus) n.h_step = 3'd3;
            else if (isdig) begin
              n.accum  = add_dig(s_q.accum, c[3:0]);
              n.h_step = 3'd3;
            end else n.h_step = 3'd4;
          end else if (s_q.h_step == 3'd3) begin
            if (isdig) n.accum = add_dig(s_q.accum, c[3:0]);
            else n.h_step = 3'd4;
          end
        end
      end
    end else begin
      // request line byte
      case (s_q.rl_step)
        3'd0, 3'd1: begin
          if (s_q.rl_step == 3'd0 && is_blank(c)) begin
            n = n;
          end else begin
            if (s_q.rl_step == 3'd0) begin
              n.mcnt = '0;
              n.kind = (c == "G") ? KGet : (c == "P") ? KPost : KOther;
            end else begin
              n.kind = s_q.kind;
            end
            n.rl_step = 3'd1;
            if (is_blank(c)) begin
              if (!((n.kind == KGet && n.mcnt == 3'd3) ||
                    (n.kind == KPost && n.mcnt == 3'd4)))
                n.kind = KOther;
              n.rl_step = 3'd2;
            end else begin
              if (n.kind == KGet && (n.mcnt >= 3'd3 || c != get_char(n.mcnt)))
                n.kind = KOther;
              if (n.kind == KPost && (n.mcnt >= 3'd4 || c != post_char(n.mcnt)))
                n.kind = KOther;
              if (n.mcnt < 3'd7) n.mcnt = n.mcnt + 1'b1;
            end
          end
        end
        3'd2: begin
          if (!is_blank(c)) begin
            n.url_start = s_q.pos;
            n.url_size  = POS_BITS'(1);
            n.rl_step   = 3'd3;
          end
        end
        3'd3: begin
          if (is_blank(c)) n.rl_step = 3'd4;
          else n.url_size = s_q.url_size + 1'b1;
        end
        3'd4: begin
          if (!is_blank(c)) begin
            n.ver_start = s_q.pos;
            n.ver_size  = POS_BITS'(1);
            n.rl_step   = 3'd5;
          end
        end
        default: n.ver_size = s_q.ver_size + 1'b1;
      endcase
    end

    // line end handling
    if (endln) begin
      if (s_q.phase == PhHdr) begin
        if (s_q.empty) begin
          if (s_q.kind == KGet) begin
            emit = 1'b1;
            verd = VERDICT_GET;
          end else if (s_q.kind == KPost) begin
            n.body_start = s_q.pos + 1'b1;
            n.remain     = s_q.length;
            if (s_q.length == '0) begin
              emit = 1'b1;
              verd = VERDICT_POST;
            end else n.phase = PhBody;
          end else emit = 1'b1;
        end else if (s_q.h_step < 3'd2) begin
          emit = 1'b1;
        end else begin
          if (s_q.flags[0] && s_q.close_m && s_q.val_idx == 3'd5) n.keep = 1'b0;
          if (s_q.flags[1]) n.length = s_q.accum;
          eline = 1'b1;
        end
      end else if (s_q.rl_step < 3'd4) begin
        emit = 1'b1;
      end else begin
        n.phase = PhHdr;
        eline   = 1'b1;
      end
    end
    if (eline) begin
      n.h_step   = '0;
      n.name_idx = '0;
      n.flags    = 2'b11;
      n.val_idx  = '0;
      n.close_m  = 1'b1;
      n.accum    = '0;
      n.empty    = 1'b1;
    end
    s_d = emit ? StRst : n;

    // result for the verdict
    res                = '0;
    res.verdict        = verd;
    res.keep_alive     = s_q.keep;
    if (verd != VERDICT_BAD) begin
      res.url_offset     = 16'(s_q.url_start);
      res.url_length     = 16'(s_q.url_size);
      res.version_offset = 16'(s_q.ver_start);
      res.version_length = 16'(s_q.ver_size);
      res.content_length = (LEN_BITS > 32 && (s_q.length >> 32) != '0) ? 32'hffff_ffff
                           : 32'(s_q.length);
    end
    if (verd == VERDICT_POST) res.body_offset = 16'(n.body_start);
  end

  // Hold the parse state; advance on each byte transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= StRst;
    end else if (take) begin
      s_q <= s_d;
    end
  end

  hrhp_out_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take && emit),
    .data_i  (res),
    .space_o (space),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  // The parser never sits in the body phase with nothing left to receive.
  a_body_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_q.phase == PhBody |-> s_q.remain != '0) else $error("body count empty");
  // A CR is never pending during the body.
  a_cr_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_q.phase == PhBody |-> !s_q.cr) else $error("cr in body");
  // Any emitted verdict returns the parser to the start of a request.
  a_reset_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && emit |=> s_q.pos == '0 && s_q.phase == PhLine)
    else $error("no restart after verdict");
`endif

endmodule
